// ===== hw/rtl/tagged_parameter_stats_defines.svh =====
// Assertion helpers for the tagged parameter statistics block
`ifndef TAGGED_PARAMETER_STATS_DEFINES_SVH
`define TAGGED_PARAMETER_STATS_DEFINES_SVH

// Check that cond implies consequent in the same cycle
`define TPS_ASSERT_IMPLY(label, cond, consequent, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (consequent)) \
    else $error(msg);

// Check that cond implies consequent in the next cycle
`define TPS_ASSERT_NEXT(label, cond, consequent, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (consequent)) \
    else $error(msg);

`endif

// ===== hw/rtl/tps_pkg.sv =====
package tps_pkg;

  localparam int unsigned WordWidth  = 16;
  localparam int unsigned CountWidth = 32;
  localparam int unsigned CfgIdxWidth = 2;

  // Register indexes of the configuration port
  localparam logic [CfgIdxWidth-1:0] REG_SEARCH_TAG  = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_WINDOW_LOW  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_WINDOW_HIGH = 2'd2;

  // Reset values and stream codes
  localparam logic [WordWidth-1:0] END_MARKER       = 16'hFFFF;
  localparam logic [WordWidth-1:0] SEARCH_TAG_RST   = 16'h8001;
  localparam logic [WordWidth-1:0] WINDOW_LOW_RST   = 16'd1;
  localparam logic [WordWidth-1:0] WINDOW_HIGH_RST  = 16'd8191;
  localparam logic [WordWidth-1:0] MIN_TRACKER_RST  = 16'hFFFF;
  localparam logic [WordWidth-1:0] MAX_TRACKER_RST  = 16'h0000;

  typedef struct packed {
    logic [WordWidth-1:0] search_tag;
    logic [WordWidth-1:0] window_low;
    logic [WordWidth-1:0] window_high;
  } cfg_t;

  typedef struct packed {
    logic [WordWidth-1:0] tag_word;
    logic [WordWidth-1:0] value_word;
  } pair_t;

  // Handshake from the input register to the statistics stage
  typedef struct packed {
    logic valid;
  } stage_ctl_t;

endpackage

// ===== hw/rtl/tps_cfg_regs.sv =====
module tps_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tps_pkg::CfgIdxWidth-1:0]    cfg_index,
  input  logic [tps_pkg::WordWidth-1:0]      cfg_data,
  output tps_pkg::cfg_t                      cfg
);
  import tps_pkg::*;

  // Write one register per enabled cycle; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.search_tag  <= SEARCH_TAG_RST;
      cfg.window_low  <= WINDOW_LOW_RST;
      cfg.window_high <= WINDOW_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEARCH_TAG:  cfg.search_tag  <= cfg_data;
        REG_WINDOW_LOW:  cfg.window_low  <= cfg_data;
        REG_WINDOW_HIGH: cfg.window_high <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/tps_input_stage.sv =====
module tps_input_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tps_pkg::WordWidth-1:0] tag_word,
  input  logic [tps_pkg::WordWidth-1:0] value_word,
  input  logic                          stage_ready,
  output tps_pkg::stage_ctl_t           ctl,
  output tps_pkg::pair_t                pair
);
  import tps_pkg::*;

  logic held_valid;

  // Stall only while a word is held and the next stage cannot take it
  assign in_stall  = held_valid && !stage_ready;
  assign ctl.valid = held_valid;

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  // Capture the word pair
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      pair.tag_word   <= tag_word;
      pair.value_word <= value_word;
    end
  end

endmodule

// ===== hw/rtl/tps_stats_core.sv =====
module tps_stats_core (
  input  logic                           clk,
  input  logic                           rst,
  input  tps_pkg::cfg_t                  cfg,
  input  tps_pkg::stage_ctl_t            ctl,
  input  tps_pkg::pair_t                 pair,
  output logic                           stage_ready,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tps_pkg::CountWidth-1:0] event_total,
  output logic [tps_pkg::CountWidth-1:0] match_total,
  output logic [tps_pkg::CountWidth-1:0] in_window_total,
  output logic [tps_pkg::WordWidth-1:0]  lowest_value,
  output logic [tps_pkg::WordWidth-1:0]  highest_value
);
  import tps_pkg::*;

  logic                  advance;
  logic                  is_marker;
  logic                  is_match;
  logic                  in_window;
  logic [CountWidth-1:0] event_next;
  logic [CountWidth-1:0] match_next;
  logic [CountWidth-1:0] window_next;
  logic [WordWidth-1:0]  lowest_next;
  logic [WordWidth-1:0]  highest_next;

  // The statistics registers double as the result register
  assign stage_ready = !out_valid || !out_stall;
  assign advance     = ctl.valid && stage_ready;

  // Classify the held pair
  assign is_marker = (pair.tag_word == END_MARKER);
  assign is_match  = (pair.tag_word == cfg.search_tag);
  assign in_window = (pair.value_word >= cfg.window_low) &&
                     (pair.value_word <= cfg.window_high);

  // Compute the updated totals
  always_comb begin
    event_next   = event_total;
    match_next   = match_total;
    window_next  = in_window_total;
    lowest_next  = lowest_value;
    highest_next = highest_value;
    if (is_marker) begin
      event_next = event_total + 32'd1;
    end
    if (is_match) begin
      match_next = match_total + 32'd1;
      if (in_window) begin
        window_next = in_window_total + 32'd1;
      end
      if (pair.value_word < lowest_value) begin
        lowest_next = pair.value_word;
      end
      if (pair.value_word > highest_value) begin
        highest_next = pair.value_word;
      end
    end
  end

  // Advance the totals and the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      event_total     <= '0;
      match_total     <= '0;
      in_window_total <= '0;
      lowest_value    <= MIN_TRACKER_RST;
      highest_value   <= MAX_TRACKER_RST;
    end else begin
      if (stage_ready) begin
        out_valid <= ctl.valid;
      end
      if (advance) begin
        event_total     <= event_next;
        match_total     <= match_next;
        in_window_total <= window_next;
        lowest_value    <= lowest_next;
        highest_value   <= highest_next;
      end
    end
  end

endmodule

// ===== hw/rtl/tagged_parameter_stats.sv =====
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  tag_word, value_word
// result    out        out_valid/out_stall  event_total .. highest_value
// config    in         cfg_we               cfg_index, cfg_data
//
// One word pair per cycle sustained while the result is not stalled; a result
// becomes valid once its pair has passed the input register (loaded at the
// accepting edge) and then the statistics register.
// The statistics registers are the result register, so totals are updated
// only when the previous result has been taken or none is pending.
// Reset (rst, synchronous) clears counters, sets the minimum to 65535, the
// maximum to 0, and loads the register defaults; no clearing pass.
// in_stall rises only while a word is held and the result is stalled.
module tagged_parameter_stats (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tps_pkg::WordWidth-1:0]    tag_word,
  input  logic [tps_pkg::WordWidth-1:0]    value_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tps_pkg::CountWidth-1:0]   event_total,
  output logic [tps_pkg::CountWidth-1:0]   match_total,
  output logic [tps_pkg::CountWidth-1:0]   in_window_total,
  output logic [tps_pkg::WordWidth-1:0]    lowest_value,
  output logic [tps_pkg::WordWidth-1:0]    highest_value,
  input  logic                             cfg_we,
  input  logic [tps_pkg::CfgIdxWidth-1:0]  cfg_index,
  input  logic [tps_pkg::WordWidth-1:0]    cfg_data
);
  import tps_pkg::*;

  `include "tagged_parameter_stats_defines.svh"

  cfg_t       cfg;
  stage_ctl_t ctl;
  pair_t      pair;
  logic       stage_ready;

  tps_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tps_input_stage u_input_stage (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .tag_word    (tag_word),
    .value_word  (value_word),
    .stage_ready (stage_ready),
    .ctl         (ctl),
    .pair        (pair)
  );

  tps_stats_core u_stats_core (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .ctl             (ctl),
    .pair            (pair),
    .stage_ready     (stage_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .event_total     (event_total),
    .match_total     (match_total),
    .in_window_total (in_window_total),
    .lowest_value    (lowest_value),
    .highest_value   (highest_value)
  );

  // Input backs up only behind a stalled, pending result
  `TPS_ASSERT_IMPLY(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without result stall")
  // Once anything matched, the minimum cannot exceed the maximum
  `TPS_ASSERT_IMPLY(a_min_le_max, match_total != '0, lowest_value <= highest_value, "minimum above maximum")
  // The window count moves only together with the match count
  `TPS_ASSERT_IMPLY(a_window_with_match, !$stable(in_window_total), !$stable(match_total), "window count moved alone")

endmodule
